>>> rtl/bpp_pkg.sv
// ----------------------------------------------------------------------------
// bpp_pkg - shared definitions for the Boris particle pusher
// Default word format, reset constants, register indexes and the command
// type passed to the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bpp_pkg;

  localparam int BPP_WORD_BITS = 48;
  localparam int BPP_FRAC_BITS = 32;

  // dt after reset, as a raw fixed-point value
  localparam longint unsigned BPP_DT_RESET = 64'd53972233;

  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_EFIELD_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EFIELD_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_EFIELD_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BFIELD_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BFIELD_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BFIELD_Z = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_QM_RATIO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_TIME_STEP = 3'd7;

  typedef enum logic {
    MODE_MUL = 1'b0,
    MODE_DIV = 1'b1
  } arith_mode_t;

  // half: the product is scaled by one extra bit (times one half)
  typedef struct packed {
    arith_mode_t mode;
    logic        half;
  } arith_cmd_t;

endpackage

`default_nettype wire

>>> rtl/boris_particle_pusher_unit.sv
// ----------------------------------------------------------------------------
// boris_particle_pusher_unit - non-relativistic Boris pusher, one particle
// Keeps position and half-step velocity; a step item advances them one step, a load item sets them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): in_op = 0 advances one step with the
//   configured fields, in_op = 1 loads position and velocity from in_load_*.
//   Each item gives one result transfer (out_valid / out_stall) carrying the
//   position and velocity after the item.
//   The block works on one item at a time; in_stall stays high from the
//   accepting edge until the result is taken.
//   A load result is offered in the cycle after the accepting edge. A step
//   runs a 43-entry sequence through one shared multiply/divide unit: 25
//   multiplies, 3 divisions and 15 saturating adds, and its result is
//   offered once the last entry has been written back. Items do not
//   overlap: a new item is taken only after the last result is taken.
//   When the receiver stalls, the result holds and no new item is taken.
//   Reset clears position and velocity to zero and loads the register
//   defaults (B = z unit field, q/m = 1.0). Write cfg_* only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module boris_particle_pusher_unit #(
  parameter int WORD_BITS = bpp_pkg::BPP_WORD_BITS,
  parameter int FRAC_BITS = bpp_pkg::BPP_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bpp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [WORD_BITS-1:0]              cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_op,
  input  wire logic [WORD_BITS-1:0]              in_load_pos_x,
  input  wire logic [WORD_BITS-1:0]              in_load_pos_y,
  input  wire logic [WORD_BITS-1:0]              in_load_pos_z,
  input  wire logic [WORD_BITS-1:0]              in_load_vel_x,
  input  wire logic [WORD_BITS-1:0]              in_load_vel_y,
  input  wire logic [WORD_BITS-1:0]              in_load_vel_z,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [WORD_BITS-1:0]                   out_pos_x,
  output logic [WORD_BITS-1:0]                   out_pos_y,
  output logic [WORD_BITS-1:0]                   out_pos_z,
  output logic [WORD_BITS-1:0]                   out_vel_x,
  output logic [WORD_BITS-1:0]                   out_vel_y,
  output logic [WORD_BITS-1:0]                   out_vel_z
);
  import bpp_pkg::*;

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam logic [5:0] LAST_STEP = 6'd42;
  localparam logic [W-1:0] FIX_ONE = W'(1) << F;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [5:0]    step_r;

  // configuration
  logic [W-1:0]  ef_r [3];
  logic [W-1:0]  bf_r [3];
  logic [W-1:0]  qm_r;
  logic [W-2:0]  dt_r;

  // particle state and step temporaries
  logic [W-1:0]  pos_r [3];
  logic [W-1:0]  vel_r [3];
  logic [W-1:0]  kick_r [3];
  logic [W-1:0]  t_r [3];
  logic [W-1:0]  s_r [3];
  logic [W-1:0]  vm_r [3];
  logic [W-1:0]  vv_r [3];
  logic [W-1:0]  vn_r [3];
  logic [W-1:0]  k_r, den_r, p_r;

  logic          use_unit, unit_start, unit_done, advance;
  arith_cmd_t    ucmd;
  logic [W-1:0]  ua, ub, ures;
  logic [W-1:0]  add_a, add_b, sum;
  logic          add_sub;
  logic [W-1:0]  dt_w;

  function automatic logic [W-1:0] sat_addsub(input logic [W-1:0] a,
                                              input logic [W-1:0] b,
                                              input logic sub);
    logic [W:0] s;
    logic [W-1:0] v;
    if (sub) s = {a[W-1], a} - {b[W-1], b};
    else     s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) v = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else                v = s[W-1:0];
    return v;
  endfunction

  assign dt_w = {1'b0, dt_r};

  // ---- operand select for the shared unit --------------------------------
  always_comb begin
    use_unit = 1'b1;
    ucmd     = '{mode: MODE_MUL, half: 1'b0};
    ua       = '0;
    ub       = '0;
    case (step_r)
      6'd0:  begin ua = qm_r;     ub = dt_w; ucmd.half = 1'b1; end
      6'd1:  begin ua = k_r;      ub = ef_r[0]; end
      6'd2:  begin ua = k_r;      ub = ef_r[1]; end
      6'd3:  begin ua = k_r;      ub = ef_r[2]; end
      6'd4:  begin ua = k_r;      ub = bf_r[0]; end
      6'd5:  begin ua = k_r;      ub = bf_r[1]; end
      6'd6:  begin ua = k_r;      ub = bf_r[2]; end
      6'd7:  begin ua = t_r[0];   ub = t_r[0]; end
      6'd8:  begin ua = t_r[1];   ub = t_r[1]; end
      6'd9:  begin ua = t_r[2];   ub = t_r[2]; end
      6'd10: begin ua = t_r[0];   ub = den_r; ucmd.mode = MODE_DIV; end
      6'd11: begin ua = t_r[1];   ub = den_r; ucmd.mode = MODE_DIV; end
      6'd12: begin ua = t_r[2];   ub = den_r; ucmd.mode = MODE_DIV; end
      // first cross product vm x t
      6'd13: begin ua = vm_r[1];  ub = t_r[2]; end
      6'd14: begin ua = t_r[1];   ub = vm_r[2]; end
      6'd16: begin ua = vm_r[2];  ub = t_r[0]; end
      6'd17: begin ua = t_r[2];   ub = vm_r[0]; end
      6'd19: begin ua = vm_r[0];  ub = t_r[1]; end
      6'd20: begin ua = t_r[0];   ub = vm_r[1]; end
      // second cross product vv x s
      6'd22: begin ua = vv_r[1];  ub = s_r[2]; end
      6'd23: begin ua = s_r[1];   ub = vv_r[2]; end
      6'd26: begin ua = vv_r[2];  ub = s_r[0]; end
      6'd27: begin ua = s_r[2];   ub = vv_r[0]; end
      6'd30: begin ua = vv_r[0];  ub = s_r[1]; end
      6'd31: begin ua = s_r[0];   ub = vv_r[1]; end
      // position advance by (v_old + v_new) * dt / 2
      6'd35: begin ua = p_r;      ub = dt_w; ucmd.half = 1'b1; end
      6'd38: begin ua = p_r;      ub = dt_w; ucmd.half = 1'b1; end
      6'd41: begin ua = p_r;      ub = dt_w; ucmd.half = 1'b1; end
      default: use_unit = 1'b0;
    endcase
  end

  // ---- operand select for the saturating adder ----------------------------
  always_comb begin
    add_a   = ures;
    add_b   = '0;
    add_sub = 1'b0;
    case (step_r)
      6'd1:  begin add_a = vel_r[0]; add_b = ures; end
      6'd2:  begin add_a = vel_r[1]; add_b = ures; end
      6'd3:  begin add_a = vel_r[2]; add_b = ures; end
      6'd7, 6'd8, 6'd9: begin add_a = den_r; add_b = ures; end
      6'd14, 6'd17, 6'd20, 6'd23, 6'd27, 6'd31: begin
        add_a = p_r; add_b = ures; add_sub = 1'b1;
      end
      6'd15: begin add_a = vm_r[0]; add_b = p_r; end
      6'd18: begin add_a = vm_r[1]; add_b = p_r; end
      6'd21: begin add_a = vm_r[2]; add_b = p_r; end
      6'd24: begin add_a = vm_r[0]; add_b = p_r; end
      6'd25: begin add_a = vn_r[0]; add_b = kick_r[0]; end
      6'd28: begin add_a = vm_r[1]; add_b = p_r; end
      6'd29: begin add_a = vn_r[1]; add_b = kick_r[1]; end
      6'd32: begin add_a = vm_r[2]; add_b = p_r; end
      6'd33: begin add_a = vn_r[2]; add_b = kick_r[2]; end
      6'd34: begin add_a = vel_r[0]; add_b = vn_r[0]; end
      6'd37: begin add_a = vel_r[1]; add_b = vn_r[1]; end
      6'd40: begin add_a = vel_r[2]; add_b = vn_r[2]; end
      6'd36: begin add_a = pos_r[0]; add_b = p_r; end
      6'd39: begin add_a = pos_r[1]; add_b = p_r; end
      6'd42: begin add_a = pos_r[2]; add_b = p_r; end
      default: ;
    endcase
  end

  assign sum = sat_addsub(add_a, add_b, add_sub);

  bpp_arith #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .cmd   (ucmd),
    .opa   (ua),
    .opb   (ub),
    .done  (unit_done),
    .res   (ures)
  );

  // ---- sequencer -----------------------------------------------------------
  assign unit_start = (state_r == ST_RUN) && use_unit;
  // write back the current entry: an add entry in RUN, a unit entry on done
  assign advance    = ((state_r == ST_RUN) && !use_unit) ||
                      ((state_r == ST_WAIT) && unit_done);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = in_op ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        if (use_unit)                    state_nxt = ST_WAIT;
        else if (step_r == LAST_STEP)    state_nxt = ST_DONE;
      end
      ST_WAIT: if (unit_done) state_nxt = ST_RUN;
      ST_DONE: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE)  step_r <= '0;
      else if (advance)        step_r <= step_r + 6'd1;
    end
  end

  // ---- configuration registers --------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ef_r[0] <= '0;
      ef_r[1] <= '0;
      ef_r[2] <= '0;
      bf_r[0] <= '0;
      bf_r[1] <= '0;
      bf_r[2] <= FIX_ONE;
      qm_r    <= FIX_ONE;
      dt_r    <= (W-1)'(BPP_DT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EFIELD_X:  ef_r[0] <= cfg_data;
        REG_EFIELD_Y:  ef_r[1] <= cfg_data;
        REG_EFIELD_Z:  ef_r[2] <= cfg_data;
        REG_BFIELD_X:  bf_r[0] <= cfg_data;
        REG_BFIELD_Y:  bf_r[1] <= cfg_data;
        REG_BFIELD_Z:  bf_r[2] <= cfg_data;
        REG_QM_RATIO:  qm_r    <= cfg_data;
        REG_TIME_STEP: dt_r    <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // ---- particle state ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else if ((state_r == ST_IDLE) && in_valid && in_op) begin
      pos_r[0] <= in_load_pos_x;
      pos_r[1] <= in_load_pos_y;
      pos_r[2] <= in_load_pos_z;
      vel_r[0] <= in_load_vel_x;
      vel_r[1] <= in_load_vel_y;
      vel_r[2] <= in_load_vel_z;
    end else if (advance) begin
      case (step_r)
        6'd36: begin pos_r[0] <= sum; vel_r[0] <= vn_r[0]; end
        6'd39: begin pos_r[1] <= sum; vel_r[1] <= vn_r[1]; end
        6'd42: begin pos_r[2] <= sum; vel_r[2] <= vn_r[2]; end
        default: ;
      endcase
    end
  end

  // ---- step temporaries ----------------------------------------------------
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      den_r <= FIX_ONE;
    end else if (advance) begin
      case (step_r)
        6'd0:  k_r <= ures;
        6'd1:  begin kick_r[0] <= ures; vm_r[0] <= sum; end
        6'd2:  begin kick_r[1] <= ures; vm_r[1] <= sum; end
        6'd3:  begin kick_r[2] <= ures; vm_r[2] <= sum; end
        6'd4:  t_r[0] <= ures;
        6'd5:  t_r[1] <= ures;
        6'd6:  t_r[2] <= ures;
        6'd7, 6'd8, 6'd9: den_r <= sum;
        6'd10: s_r[0] <= ures;
        6'd11: s_r[1] <= ures;
        6'd12: s_r[2] <= ures;
        6'd13, 6'd16, 6'd19, 6'd22, 6'd26, 6'd30, 6'd35, 6'd38, 6'd41: p_r <= ures;
        6'd14, 6'd17, 6'd20, 6'd23, 6'd27, 6'd31, 6'd34, 6'd37, 6'd40: p_r <= sum;
        6'd15: vv_r[0] <= sum;
        6'd18: vv_r[1] <= sum;
        6'd21: vv_r[2] <= sum;
        6'd24, 6'd25: vn_r[0] <= sum;
        6'd28, 6'd29: vn_r[1] <= sum;
        6'd32, 6'd33: vn_r[2] <= sum;
        default: ;
      endcase
    end
  end

  // ---- ports ---------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_pos_x = pos_r[0];
  assign out_pos_y = pos_r[1];
  assign out_pos_z = pos_r[2];
  assign out_vel_x = vel_r[0];
  assign out_vel_y = vel_r[1];
  assign out_vel_z = vel_r[2];

  // ---- checks --------------------------------------------------------------
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result pending while input is open");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    unit_done |-> (state_r == ST_WAIT))
    else $error("arith result arrived outside wait state");

  a_start_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    unit_start |=> !unit_done)
    else $error("arith unit answered in one cycle");

endmodule

`default_nettype wire

>>> rtl/bpp_arith.sv
// ----------------------------------------------------------------------------
// bpp_arith - shared multiply / divide unit
// Rounded, saturating fixed-point multiply over four partial products, and
// the rotation factor 2*a/b by restoring division, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_arith #(
  parameter int WORD_BITS = bpp_pkg::BPP_WORD_BITS,
  parameter int FRAC_BITS = bpp_pkg::BPP_FRAC_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire bpp_pkg::arith_cmd_t     cmd,
  input  wire logic [WORD_BITS-1:0]    opa,
  input  wire logic [WORD_BITS-1:0]    opb,
  output logic                         done,
  output logic [WORD_BITS-1:0]         res
);
  import bpp_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int H   = (W + 1) / 2;
  localparam int P2  = 2 * W;
  localparam int CW  = $clog2(W + 1);

  typedef enum logic [4:0] {
    AU_IDLE = 5'b00001,
    AU_MUL  = 5'b00010,
    AU_MRND = 5'b00100,
    AU_DIV  = 5'b01000,
    AU_DRND = 5'b10000
  } au_state_t;

  au_state_t         state_r, state_nxt;
  logic              neg_r, half_r;
  logic [W-1:0]      ma_r, mb_r;
  logic [1:0]        phase_r;
  logic [P2-1:0]     acc_r;
  logic [W-1:0]      rem_r;
  logic [W:0]        num_r;
  logic [W:0]        q_r;
  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic [W-1:0]      res_r;

  logic [W-1:0]      mag_a, mag_b;
  logic [H-1:0]      pa, pb;
  logic [2*H-1:0]    pp;
  logic [P2-1:0]     pp_sh;
  logic [P2-1:0]     rnd, shv;
  logic [W:0]        remsh;
  logic              fit;
  logic [W+1:0]      qr;
  logic              up;
  logic [W-1:0]      mres, dres;

  function automatic logic [W-1:0] sat_res(input logic neg, input logic over,
                                           input logic [W-1:0] m);
    logic [W-1:0] v;
    if (over) begin
      v = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      v = neg ? (~m + 1'b1) : m;
    end
    return v;
  endfunction

  assign mag_a = opa[W-1] ? (~opa + 1'b1) : opa;
  assign mag_b = opb[W-1] ? (~opb + 1'b1) : opb;

  // partial product select: low/high halves of each magnitude
  assign pa = phase_r[0] ? H'(ma_r[W-1:H]) : ma_r[H-1:0];
  assign pb = phase_r[1] ? H'(mb_r[W-1:H]) : mb_r[H-1:0];
  assign pp = pa * pb;

  always_comb begin
    case (phase_r)
      2'd0:    pp_sh = P2'(pp);
      2'd3:    pp_sh = P2'(pp) << (2 * H);
      default: pp_sh = P2'(pp) << H;
    endcase
  end

  assign rnd  = acc_r + (half_r ? (P2'(1) << F) : (P2'(1) << (F - 1)));
  assign shv  = half_r ? (rnd >> (F + 1)) : (rnd >> F);
  assign mres = sat_res(neg_r, |shv[P2-1:W-1], shv[W-1:0]);

  assign remsh = {rem_r, num_r[W]};
  assign fit   = remsh >= {1'b0, mb_r};
  assign up    = rem_r >= (mb_r - rem_r);
  assign qr    = {1'b0, q_r} + (W+2)'(up);
  assign dres  = sat_res(neg_r, |qr[W+1:W-1], qr[W-1:0]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      AU_IDLE: begin
        if (start) begin
          state_nxt = (cmd.mode == MODE_DIV) ? AU_DIV : AU_MUL;
        end
      end
      AU_MUL:  if (phase_r == 2'd3) state_nxt = AU_MRND;
      AU_MRND: state_nxt = AU_IDLE;
      AU_DIV:  if (cnt_r == CW'(W)) state_nxt = AU_DRND;
      AU_DRND: state_nxt = AU_IDLE;
      default: state_nxt = AU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AU_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == AU_MRND) || (state_r == AU_DRND);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      AU_IDLE: begin
        if (start) begin
          half_r  <= cmd.half;
          phase_r <= 2'd0;
          acc_r   <= '0;
          cnt_r   <= '0;
          q_r     <= '0;
          if (cmd.mode == MODE_DIV) begin
            // numerator is |a| << (F+1); its top part is already below the divisor
            neg_r <= opa[W-1];
            mb_r  <= opb;
            rem_r <= mag_a >> (W - F);
            num_r <= {mag_a[W-F-1:0], {(F+1){1'b0}}};
          end else begin
            neg_r <= opa[W-1] ^ opb[W-1];
            ma_r  <= mag_a;
            mb_r  <= mag_b;
          end
        end
      end
      AU_MUL: begin
        acc_r   <= acc_r + pp_sh;
        phase_r <= phase_r + 2'd1;
      end
      AU_MRND: res_r <= mres;
      AU_DIV: begin
        rem_r <= fit ? W'(remsh - {1'b0, mb_r}) : remsh[W-1:0];
        q_r   <= {q_r[W-1:0], fit};
        num_r <= {num_r[W-1:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      AU_DRND: res_r <= dres;
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire
